@@ hw/rtl/upbrb_pkg.sv @@
// Package for the UART packed byte ring buffers: ring sizes, derived widths,
// the item kind codes and the input and result beat structs.
// No dependencies.
`timescale 1ns / 1ps

package upbrb_pkg;

	localparam int RX_WORDS = 8;
	localparam int TX_WORDS = 8;

	localparam int RX_BYTES = 2 * RX_WORDS;
	localparam int TX_BYTES = 2 * TX_WORDS;

	localparam int RX_AW = (RX_WORDS > 1) ? $clog2(RX_WORDS) : 1;
	localparam int TX_AW = (TX_WORDS > 1) ? $clog2(TX_WORDS) : 1;
	localparam int RX_PW = $clog2(RX_BYTES);
	localparam int TX_PW = $clog2(TX_BYTES);
	localparam int RX_FW = $clog2(RX_BYTES + 1);
	localparam int TX_FW = $clog2(TX_BYTES + 1);

	localparam int WORD_W  = 16;
	localparam int LEVEL_W = 5;

	typedef enum logic [1:0] {
		KIND_RX_BYTE   = 2'd0,
		KIND_HOST_READ = 2'd1,
		KIND_HOST_WRITE = 2'd2,
		KIND_TX_EMPTY  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       rx_error;
		logic       transmitter_ready;
	} in_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               read_valid;
		logic               send_valid;
		logic               write_accepted;
		logic               rx_dropped;
		logic [LEVEL_W-1:0] rx_level;
		logic [LEVEL_W-1:0] tx_level;
		logic               tx_irq_armed;
	} out_t;

endpackage

@@ hw/rtl/upbrb_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module upbrb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/uart_packed_byte_ring_buffers.sv @@
// Top level of the UART packed byte ring buffers: receive and transmit rings
// of bytes packed two to a word. Uses upbrb_pkg and two upbrb_ram instances.
//
// Usage: an item beat is taken on a rising edge where start is high and busy
// is low. The item kind selects a received byte, a host read, a host write or
// a transmitter-empty event. Each item gives exactly one result beat, shown on
// result for one cycle while done is high; the receiver cannot stall it.
//
// Latency: an item taken at edge N holds busy high for the next cycle, and its
// result is on the ports in the cycle after that. A new item may be taken in
// the same cycle the previous result is shown, so one item enters every two
// cycles. The figure is set by the one-port word memory of each ring: the
// first cycle reads the packed word, the second merges the byte and writes it
// back while the pointers and byte counts update.
//
// Reset clears both rings to empty, all pointers to zero and the transmit
// interrupt enable; done is low after reset. The stored words need no clearing
// pass since a byte is only read after it was written.
`timescale 1ns / 1ps

module uart_packed_byte_ring_buffers
	import upbrb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  in_t  item,
	output logic busy,
	output logic done,
	output out_t result
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	in_t    item_s1;

	logic [RX_PW-1:0] rx_wpos_q, rx_rpos_q, rx_wpos_d, rx_rpos_d;
	logic [TX_PW-1:0] tx_wpos_q, tx_rpos_q, tx_wpos_d, tx_rpos_d;
	logic [RX_FW-1:0] rx_fill_q, rx_fill_d;
	logic [TX_FW-1:0] tx_fill_q, tx_fill_d;
	logic             irq_q, irq_d;

	out_t result_q, result_d;
	logic done_q;

	logic              accept;
	logic              rx_en, rx_we, tx_en, tx_we;
	logic [RX_AW-1:0]  rx_addr;
	logic [TX_AW-1:0]  tx_addr;
	logic [WORD_W-1:0] rx_rdata, tx_rdata, rx_wdata, tx_wdata;

	assign busy   = (state_q == ST_EXEC);
	assign accept = start && !busy;

	function automatic logic [RX_PW-1:0] rx_next(input logic [RX_PW-1:0] pos);
		return (pos == RX_PW'(RX_BYTES - 1)) ? '0 : pos + 1'b1;
	endfunction

	function automatic logic [TX_PW-1:0] tx_pos_inc(input logic [TX_PW-1:0] pos);
		return pos + 1'b1;
	endfunction

	function automatic logic [TX_PW-1:0] tx_next(input logic [TX_PW-1:0] pos);
		return (pos == TX_PW'(TX_BYTES - 1)) ? '0 : tx_pos_inc(pos);
	endfunction

	always_comb begin
		if (busy) begin
			rx_addr = RX_AW'(rx_wpos_q >> 1);
			tx_addr = TX_AW'(tx_wpos_q >> 1);
		end else begin
			rx_addr = (item.kind == KIND_RX_BYTE) ? RX_AW'(rx_wpos_q >> 1)
				: RX_AW'(rx_rpos_q >> 1);
			tx_addr = (item.kind == KIND_HOST_WRITE) ? TX_AW'(tx_wpos_q >> 1)
				: TX_AW'(tx_rpos_q >> 1);
		end
	end

	assign rx_en = accept || rx_we;
	assign tx_en = accept || tx_we;

	assign rx_wdata = rx_wpos_q[0] ? {item_s1.data_byte, rx_rdata[7:0]}
		: {rx_rdata[15:8], item_s1.data_byte};
	assign tx_wdata = tx_wpos_q[0] ? {item_s1.data_byte, tx_rdata[7:0]}
		: {tx_rdata[15:8], item_s1.data_byte};

	upbrb_ram #(.WIDTH(WORD_W), .DEPTH(RX_WORDS)) u_rx_ram (
		.clk   (clk),
		.en    (rx_en),
		.we    (rx_we),
		.addr  (rx_addr),
		.wdata (rx_wdata),
		.rdata (rx_rdata)
	);

	upbrb_ram #(.WIDTH(WORD_W), .DEPTH(TX_WORDS)) u_tx_ram (
		.clk   (clk),
		.en    (tx_en),
		.we    (tx_we),
		.addr  (tx_addr),
		.wdata (tx_wdata),
		.rdata (tx_rdata)
	);

	always_comb begin
		rx_wpos_d = rx_wpos_q;
		rx_rpos_d = rx_rpos_q;
		rx_fill_d = rx_fill_q;
		tx_wpos_d = tx_wpos_q;
		tx_rpos_d = tx_rpos_q;
		tx_fill_d = tx_fill_q;
		irq_d     = irq_q;
		rx_we     = 1'b0;
		tx_we     = 1'b0;
		result_d  = '0;
		if (busy) begin
			unique case (item_s1.kind)
				KIND_RX_BYTE: begin
					if (item_s1.rx_error || (rx_fill_q >= RX_FW'(RX_BYTES))) begin
						result_d.rx_dropped = 1'b1;
					end else begin
						rx_we     = 1'b1;
						rx_fill_d = rx_fill_q + 1'b1;
						rx_wpos_d = rx_next(rx_wpos_q);
					end
				end
				KIND_HOST_READ: begin
					if (rx_fill_q != '0) begin
						result_d.out_byte   = rx_rpos_q[0] ? rx_rdata[15:8] : rx_rdata[7:0];
						result_d.read_valid = 1'b1;
						rx_fill_d = rx_fill_q - 1'b1;
						rx_rpos_d = rx_next(rx_rpos_q);
					end
				end
				KIND_HOST_WRITE: begin
					if (tx_fill_q < TX_FW'(TX_BYTES)) begin
						result_d.write_accepted = 1'b1;
						if (item_s1.transmitter_ready && (tx_fill_q == '0)) begin
							result_d.out_byte   = item_s1.data_byte;
							result_d.send_valid = 1'b1;
							irq_d = 1'b1;
						end else begin
							tx_we     = 1'b1;
							tx_fill_d = tx_fill_q + 1'b1;
							tx_wpos_d = tx_next(tx_wpos_q);
						end
					end
				end
				KIND_TX_EMPTY: begin
					if (tx_fill_q != '0) begin
						result_d.out_byte   = tx_rpos_q[0] ? tx_rdata[15:8] : tx_rdata[7:0];
						result_d.send_valid = 1'b1;
						tx_fill_d = tx_fill_q - 1'b1;
						tx_rpos_d = tx_next(tx_rpos_q);
					end else begin
						irq_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
		result_d.rx_level     = LEVEL_W'(rx_fill_d);
		result_d.tx_level     = LEVEL_W'(tx_fill_d);
		result_d.tx_irq_armed = irq_d;
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: state_d = accept ? ST_EXEC : ST_IDLE;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rx_wpos_q <= '0;
			rx_rpos_q <= '0;
			rx_fill_q <= '0;
			tx_wpos_q <= '0;
			tx_rpos_q <= '0;
			tx_fill_q <= '0;
			irq_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rx_wpos_q <= rx_wpos_d;
			rx_rpos_q <= rx_rpos_d;
			rx_fill_q <= rx_fill_d;
			tx_wpos_q <= tx_wpos_d;
			tx_rpos_q <= tx_rpos_d;
			tx_fill_q <= tx_fill_d;
			irq_q     <= irq_d;
			done_q    <= busy;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (busy) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC))
		else $error("Result beat without a preceding execute cycle.");

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Accepted item did not enter the execute cycle.");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_fill_q <= RX_FW'(RX_BYTES)) && (tx_fill_q <= TX_FW'(TX_BYTES)))
		else $error("Ring byte count exceeds its capacity.");

	a_one_byte_use: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.read_valid && result.send_valid))
		else $error("Result byte marked both as read and as sent.");

endmodule
